### design/epm_pkg.sv
package epm_pkg;

  localparam int POOL_BYTES_DEF = 64;

  localparam logic [1:0] ACT_ABSORB = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DUMP
  } epm_state_t;

  function automatic logic [7:0] rotl1(input logic [7:0] v);
    return {v[6:0], v[7]};
  endfunction

endpackage

### design/epm_pool_ram.sv
module epm_pool_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= written[raddr] ? mem[raddr] : 8'd0;
    end
  end

endmodule

### design/entropy_pool_mixer_unit.sv
// Entropy pool mixer.
// Input channel (in_valid/in_ready) carries action, data_byte and call_end.
// Output channel (out_valid/out_ready) carries out_byte, out_source, out_last.
// While collecting, an absorbed word is mixed into the pool: the entry at the
// write index is read, rotated left by one, XORed with the byte and written
// back in the next cycle. Collecting absorbs, stops and starts give no
// result; a start with words collected then dumps that many pool words at
// one word per cycle from the memory read port while the receiver keeps up.
// While forwarding, an absorbed word appears on the output the cycle after
// it is accepted; one such word per cycle when the receiver keeps up.
// Input is held off during a dump, and while forwarding whenever the output
// register is full and not being taken. Collecting absorbs are still taken
// while a result waits.
// Reset clears all control state; pool entries read as zero until written,
// so no clearing pass is needed.
module entropy_pool_mixer_unit
  import epm_pkg::*;
#(
  parameter int POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic       call_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_source,
  output logic       out_last
);

  localparam int AW = $clog2(POOL_BYTES);
  localparam int CW = $clog2(POOL_BYTES + 1);

  epm_state_t    state, state_next;
  logic          forwarding;
  logic [AW-1:0] write_index;
  logic [CW-1:0] collected_count;
  logic [CW-1:0] call_position;
  logic          mix_wb;
  logic [AW-1:0] mix_addr;
  logic [7:0]    mix_data;
  logic [CW-1:0] dump_cnt;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] ld_idx;
  logic          rd_pend;

  logic          slot_free, in_fire, mix_go, pass_go, start_go, stop_go;
  logic          dump_issue, dump_load, dump_last;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign slot_free = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign mix_go    = in_fire && (action == ACT_ABSORB) && !forwarding &&
                     (call_position < CW'(POOL_BYTES));
  assign pass_go   = in_fire && (action == ACT_ABSORB) && forwarding;
  assign start_go  = in_fire && (action == ACT_START);
  assign stop_go   = in_fire && (action == ACT_STOP);
  assign dump_last = (ld_idx + CW'(1)) == dump_cnt;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_go && (collected_count != '0)) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (dump_load && dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    dump_load  = 1'b0;
    dump_issue = 1'b0;
    ram_raddr  = write_index;
    case (state)
      ST_IDLE: begin
        in_ready = !forwarding || slot_free;
      end
      ST_DUMP: begin
        // ram output register acts as the skid stage for dump words
        dump_load  = rd_pend && slot_free;
        dump_issue = (rd_idx != dump_cnt) && (!rd_pend || dump_load);
        ram_raddr  = rd_idx[AW-1:0];
      end
      default: ;
    endcase
  end

  assign ram_re = mix_go || dump_issue;

  epm_pool_ram #(
    .DEPTH (POOL_BYTES),
    .AW    (AW)
  ) u_pool (
    .clk   (clk),
    .rst   (rst),
    .we    (mix_wb),
    .waddr (mix_addr),
    .wdata (rotl1(ram_rdata) ^ mix_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      forwarding      <= 1'b0;
      write_index     <= '0;
      collected_count <= '0;
      call_position   <= '0;
      mix_wb          <= 1'b0;
      rd_pend         <= 1'b0;
      out_valid       <= 1'b0;
      dump_cnt        <= '0;
      rd_idx          <= '0;
      ld_idx          <= '0;
    end else begin
      state  <= state_next;
      mix_wb <= mix_go;

      if (mix_go) begin
        write_index <= (write_index == AW'(POOL_BYTES - 1)) ? '0 : write_index + AW'(1);
        if (collected_count < CW'(POOL_BYTES)) begin
          collected_count <= collected_count + CW'(1);
        end
      end

      if (in_fire && (action == ACT_ABSORB)) begin
        if (call_end) begin
          call_position <= '0;
        end else if (call_position < CW'(POOL_BYTES)) begin
          call_position <= call_position + CW'(1);
        end
      end else if (start_go || stop_go) begin
        call_position <= '0;
      end

      if (start_go) begin
        forwarding      <= 1'b1;
        collected_count <= '0;
        dump_cnt        <= collected_count;
        rd_idx          <= '0;
        ld_idx          <= '0;
      end else if (stop_go) begin
        forwarding <= 1'b0;
      end

      if (dump_issue) begin
        rd_idx  <= rd_idx + CW'(1);
        rd_pend <= 1'b1;
      end else if (dump_load) begin
        rd_pend <= 1'b0;
      end

      if (dump_load) begin
        ld_idx <= ld_idx + CW'(1);
      end

      if (pass_go || dump_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mix_go) begin
      mix_addr <= write_index;
      mix_data <= data_byte;
    end
    if (pass_go) begin
      out_byte   <= data_byte;
      out_source <= 1'b0;
      out_last   <= 1'b1;
    end else if (dump_load) begin
      out_byte   <= ram_rdata;
      out_source <= 1'b1;
      out_last   <= dump_last;
    end
  end

endmodule
